@@ design/sab_pkg.sv @@
// Shared constants, command and status types for the suffix array builder.
package sab_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int SYM_W       = 8;
  localparam int POS_W       = 6;
  localparam int SEC_W       = SYM_W + 1;
  localparam int KEY_W       = SYM_W + SEC_W;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_LOAD_LAST,
    OP_K0_RD,
    OP_K0_WR,
    OP_SI_RD,
    OP_SI_LATCH,
    OP_SJ_RD,
    OP_SJ_CMP,
    OP_S_WR,
    OP_R_RD_ORD,
    OP_R_RD_KEY,
    OP_R_WR,
    OP_RB_RD,
    OP_RB_WR,
    OP_O_RD,
    OP_O_SHOW
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic k_ge_n;
    logic ranks_full;
  } dp_stat_t;

endpackage

@@ design/sab_if.sv @@
// Valid/ready channel interfaces for text bytes and suffix positions.
interface sab_in_if import sab_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             final_req;

  modport source (output valid, output symbol, output final_req, input ready);
  modport sink   (input valid, input symbol, input final_req, output ready);
endinterface

interface sab_out_if import sab_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             end_of_run;

  modport source (output valid, output position, output end_of_run, input ready);
  modport sink   (input valid, input position, input end_of_run, output ready);
endinterface

@@ design/sab_datapath.sv @@
// Datapath: text, key, rank and order memories, loop counters and compares.
module sab_datapath import sab_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic [SYM_W-1:0] in_symbol,
  output dp_stat_t         stat,
  output logic [POS_W-1:0] out_position,
  output logic             out_end_of_run
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [SYM_W-1:0] text_mem  [MAX_LEN];
  logic [KEY_W-1:0] key_mem   [MAX_LEN];
  logic [AW-1:0]    rank_mem  [MAX_LEN];
  logic [AW-1:0]    order_mem [MAX_LEN];

  logic [SYM_W-1:0] text_qa_r, text_qb_r;
  logic [KEY_W-1:0] key_q_r;
  logic [AW-1:0]    rank_qa_r, rank_qb_r;
  logic [AW-1:0]    order_q_r;

  logic [CW-1:0]    len_r, len_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    rank_r, rank_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [KEY_W-1:0] ki_r, ki_nxt;
  logic [KEY_W-1:0] prev_r, prev_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             end_r, end_nxt;

  logic [AW-1:0]    i_a, ti_b, rk_b, key_a;
  logic [CW:0]      ik_sum;
  logic             i_last, j_last, key_less;
  logic [AW-1:0]    r_cur;
  logic [KEY_W-1:0] key_k0, key_rb;

  assign i_a    = i_r[AW-1:0];
  assign ti_b   = i_a + AW'(1);
  assign ik_sum = {1'b0, i_r} + {1'b0, k_r};
  assign rk_b   = ik_sum[AW-1:0];

  assign i_last = (i_r == n_r - CW'(1));
  assign j_last = (j_r == n_r - CW'(1));

  assign key_less = (key_q_r < ki_r) || ((key_q_r == ki_r) && (j_r < i_r));
  assign r_cur    = (i_r == '0) ? '0 :
                    ((key_q_r != prev_r) ? rank_r + AW'(1) : rank_r);

  assign key_k0 = {text_qa_r,
                   ((i_r + CW'(1)) < n_r) ? (SEC_W'(text_qb_r) + SEC_W'(1)) : SEC_W'(0)};
  assign key_rb = {SYM_W'(rank_qa_r),
                   (ik_sum < {1'b0, n_r}) ? (SEC_W'(rank_qb_r) + SEC_W'(1)) : SEC_W'(0)};

  assign stat.i_last     = i_last;
  assign stat.j_last     = j_last;
  assign stat.k_ge_n     = (k_r >= n_r);
  assign stat.ranks_full = ({1'b0, r_cur} == CW'(n_r - CW'(1)));

  always_comb begin
    unique case (cmd.op)
      OP_SJ_RD:    key_a = j_r[AW-1:0];
      OP_R_RD_KEY: key_a = order_q_r;
      default:     key_a = i_a;
    endcase
  end

  // Memory ports: registered reads every cycle, writes by command.
  always_ff @(posedge clk) begin
    text_qa_r <= text_mem[i_a];
    text_qb_r <= text_mem[ti_b];
    key_q_r   <= key_mem[key_a];
    rank_qa_r <= rank_mem[i_a];
    rank_qb_r <= rank_mem[rk_b];
    order_q_r <= order_mem[i_a];
    if (((cmd.op == OP_LOAD) || (cmd.op == OP_LOAD_LAST)) && (len_r < CW'(MAX_LEN))) begin
      text_mem[len_r[AW-1:0]] <= in_symbol;
    end
    if (cmd.op == OP_K0_WR) begin
      key_mem[i_a] <= key_k0;
    end else if (cmd.op == OP_RB_WR) begin
      key_mem[i_a] <= key_rb;
    end
    if (cmd.op == OP_S_WR) begin
      order_mem[cnt_r] <= i_a;
    end
    if (cmd.op == OP_R_WR) begin
      rank_mem[idx_r] <= r_cur;
    end
  end

  always_comb begin
    len_nxt  = len_r;
    n_nxt    = n_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    rank_nxt = rank_r;
    idx_nxt  = idx_r;
    ki_nxt   = ki_r;
    prev_nxt = prev_r;
    pos_nxt  = pos_r;
    end_nxt  = end_r;
    unique case (cmd.op)
      OP_LOAD: begin
        if (len_r < CW'(MAX_LEN)) len_nxt = len_r + CW'(1);
      end
      OP_LOAD_LAST: begin
        n_nxt   = (len_r < CW'(MAX_LEN)) ? len_r + CW'(1) : len_r;
        len_nxt = '0;
        i_nxt   = '0;
        j_nxt   = '0;
        k_nxt   = CW'(2);
      end
      OP_SI_LATCH: begin
        ki_nxt  = key_q_r;
        cnt_nxt = '0;
      end
      OP_SJ_CMP: begin
        if (key_less) cnt_nxt = cnt_r + AW'(1);
        j_nxt = j_last ? '0 : j_r + CW'(1);
      end
      OP_R_RD_KEY: idx_nxt = order_q_r;
      OP_R_WR: begin
        rank_nxt = r_cur;
        prev_nxt = key_q_r;
        i_nxt    = i_last ? '0 : i_r + CW'(1);
      end
      OP_RB_WR: begin
        i_nxt = i_last ? '0 : i_r + CW'(1);
        if (i_last) k_nxt = {k_r[CW-2:0], 1'b0};
      end
      OP_K0_WR, OP_S_WR: i_nxt = i_last ? '0 : i_r + CW'(1);
      OP_O_SHOW: begin
        pos_nxt = POS_W'(order_q_r);
        end_nxt = i_last;
        i_nxt   = i_last ? '0 : i_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      n_r   <= CW'(1);
      i_r   <= '0;
      j_r   <= '0;
      k_r   <= CW'(2);
    end else begin
      len_r <= len_nxt;
      n_r   <= n_nxt;
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      k_r   <= k_nxt;
    end
    cnt_r  <= cnt_nxt;
    rank_r <= rank_nxt;
    idx_r  <= idx_nxt;
    ki_r   <= ki_nxt;
    prev_r <= prev_nxt;
    pos_r  <= pos_nxt;
    end_r  <= end_nxt;
  end

  assign out_position   = pos_r;
  assign out_end_of_run = end_r;

endmodule

@@ design/sab_controller.sv @@
// Controller: sequences load, key build, sort, rank and output passes.
module sab_controller import sab_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_final,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_LOAD, ST_K0_RD, ST_K0_WR, ST_SI_RD, ST_SI_LATCH, ST_SJ_RD, ST_SJ_CMP,
    ST_S_WR, ST_R_ORD, ST_R_KEY, ST_R_WR, ST_RB_RD, ST_RB_WR, ST_O_RD, ST_O_SHOW
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_IDLE;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.op = in_final ? OP_LOAD_LAST : OP_LOAD;
          if (in_final) state_nxt = ST_K0_RD;
        end
      end
      ST_K0_RD: begin
        cmd.op    = OP_K0_RD;
        state_nxt = ST_K0_WR;
      end
      ST_K0_WR: begin
        cmd.op    = OP_K0_WR;
        state_nxt = stat.i_last ? ST_SI_RD : ST_K0_RD;
      end
      ST_SI_RD: begin
        cmd.op    = OP_SI_RD;
        state_nxt = ST_SI_LATCH;
      end
      ST_SI_LATCH: begin
        cmd.op    = OP_SI_LATCH;
        state_nxt = ST_SJ_RD;
      end
      ST_SJ_RD: begin
        cmd.op    = OP_SJ_RD;
        state_nxt = ST_SJ_CMP;
      end
      ST_SJ_CMP: begin
        cmd.op    = OP_SJ_CMP;
        state_nxt = stat.j_last ? ST_S_WR : ST_SJ_RD;
      end
      ST_S_WR: begin
        cmd.op = OP_S_WR;
        if (!stat.i_last)     state_nxt = ST_SI_RD;
        else if (stat.k_ge_n) state_nxt = ST_O_RD;
        else                  state_nxt = ST_R_ORD;
      end
      ST_R_ORD: begin
        cmd.op    = OP_R_RD_ORD;
        state_nxt = ST_R_KEY;
      end
      ST_R_KEY: begin
        cmd.op    = OP_R_RD_KEY;
        state_nxt = ST_R_WR;
      end
      ST_R_WR: begin
        cmd.op = OP_R_WR;
        if (!stat.i_last)         state_nxt = ST_R_ORD;
        else if (stat.ranks_full) state_nxt = ST_O_RD;
        else                      state_nxt = ST_RB_RD;
      end
      ST_RB_RD: begin
        cmd.op    = OP_RB_RD;
        state_nxt = ST_RB_WR;
      end
      ST_RB_WR: begin
        cmd.op    = OP_RB_WR;
        state_nxt = stat.i_last ? ST_SI_RD : ST_RB_RD;
      end
      ST_O_RD: begin
        cmd.op = OP_O_RD;
        if (!out_valid_r || out_ready) state_nxt = ST_O_SHOW;
      end
      ST_O_SHOW: begin
        cmd.op    = OP_O_SHOW;
        state_nxt = stat.i_last ? ST_LOAD : ST_O_RD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_valid_nxt = (state_r == ST_O_SHOW) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;

endmodule

@@ design/suffix_array_builder_top.sv @@
// Top level of the suffix array builder: controller plus datapath.
// Text bytes transfer in at one per cycle; the byte flagged final_req ends the
// text (at most MAX_LEN bytes are kept, later bytes are dropped) and starts the
// build, during which in.ready is low. For a text of n bytes the build makes
// the first keys, then per round runs a sort, a rank pass and a key rebuild;
// rounds double the offset from 2 and stop once all ranks differ or the
// offset reaches n, so at most about log2(n) rounds run. The sort cost is set
// by the single read port of the key memory, which the compare loop walks one
// key at a time, reading each key and then comparing it. Results then transfer
// out one at a time, each read and then shown once the output register is free,
// position in sorted order, end_of_run on the last; the next text may start
// transferring in while the last result still waits in the output register.
// All memories start undefined and need no clearing pass.
module suffix_array_builder_top import sab_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input logic      clk,
  input logic      rst_n,
  sab_in_if.sink   in_ch,
  sab_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the passes; hold the output valid until the transfer completes.
  sab_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_final  (in_ch.final_req),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store the text, build keys, sort by counting, rank, and present results.
  sab_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_symbol      (in_ch.symbol),
    .stat           (stat),
    .out_position   (out_ch.position),
    .out_end_of_run (out_ch.end_of_run)
  );

endmodule

@@ design/sab_checker.sv @@
// Port-level assertions for the suffix array builder, bound to the top level.
module sab_checker import sab_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_final,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] out_position,
  input logic             out_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position))
    else $error("result dropped or changed while stalled");

  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("input taken right after the final byte");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_end |=> !in_ready)
    else $error("input taken before the run of results ended");

  a_no_out_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !out_valid |=> !out_valid)
    else $error("result appeared while loading text");

endmodule

bind suffix_array_builder_top sab_checker u_sab_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_final     (in_ch.final_req),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_position (out_ch.position),
  .out_end      (out_ch.end_of_run)
);
